// File: rtl/core/icmphfe_pkg.sv
`timescale 1ns / 1ps

package icmphfe_pkg;

	// Width of the saturating byte offset counter.
	localparam int OFFSET_WIDTH = 16;
	localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

	// Byte offsets within the ICMP message.
	localparam logic [OFFSET_WIDTH-1:0] OFS_HEAD_END   = OFFSET_WIDTH'(8);
	localparam logic [OFFSET_WIDTH-1:0] OFS_VER_LEN    = OFFSET_WIDTH'(8);
	localparam logic [OFFSET_WIDTH-1:0] OFS_PROTO      = OFFSET_WIDTH'(17);
	localparam logic [OFFSET_WIDTH-1:0] OFS_ADDR_FIRST = OFFSET_WIDTH'(20);
	localparam logic [OFFSET_WIDTH-1:0] OFS_ADDR_LAST  = OFFSET_WIDTH'(27);
	localparam logic [OFFSET_WIDTH-1:0] OFS_PORT_LEN   = OFFSET_WIDTH'(4);

	// First last-byte offsets at which a message counts as short or full.
	localparam logic [OFFSET_WIDTH-1:0] POS_MIN_SHORT = OFFSET_WIDTH'(3);
	localparam logic [OFFSET_WIDTH-1:0] POS_MIN_FULL  = OFFSET_WIDTH'(7);
	// The transport ports end at offset 11 plus the embedded header length in bytes.
	localparam logic [OFFSET_WIDTH-1:0] POS_PORTS_END = OFFSET_WIDTH'(11);

	// ICMP error types that carry an embedded IPv4 header.
	localparam logic [7:0] TYPE_DEST_UNREACH   = 8'd3;
	localparam logic [7:0] TYPE_REDIRECT       = 8'd5;
	localparam logic [7:0] TYPE_TIME_EXCEEDED  = 8'd11;
	localparam logic [7:0] TYPE_PARAM_PROBLEM  = 8'd12;

	// Embedded IPv4 header codes.
	localparam logic [3:0] IP_VERSION_4 = 4'h4;
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [7:0] PROTO_UDP    = 8'd17;

	typedef enum logic [1:0] {
		STATUS_TRUNCATED = 2'd0,
		STATUS_SHORT     = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	// Captured message state including the byte currently being absorbed.
	typedef struct packed {
		logic [OFFSET_WIDTH-1:0] pos;
		logic [63:0]             head;
		logic [7:0]              ver_len;
		logic [7:0]              proto;
		logic [63:0]             addr;
		logic [31:0]             ports;
	} cap_view_t;

	// One result record.
	typedef struct packed {
		status_t     status;
		logic [7:0]  msg_type;
		logic [7:0]  msg_code;
		logic [15:0] echo_id;
		logic [15:0] echo_seq;
		logic        inner_valid;
		logic [7:0]  inner_proto;
		logic [31:0] inner_src;
		logic [31:0] inner_dst;
		logic        ports_valid;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} rec_t;

endpackage

// File: rtl/core/icmphfe_capture.sv
`timescale 1ns / 1ps

module icmphfe_capture (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	output icmphfe_pkg::cap_view_t view
);
	import icmphfe_pkg::*;

	logic [OFFSET_WIDTH-1:0] offset_q;
	logic [63:0]             head_q;
	logic [7:0]              ver_len_q;
	logic [7:0]              proto_q;
	logic [63:0]             addr_q;
	logic [31:0]             ports_q;

	logic [7:0]              vl_sel;
	logic [OFFSET_WIDTH-1:0] port_start;
	logic [OFFSET_WIDTH-1:0] port_diff;
	logic [OFFSET_WIDTH-1:0] addr_diff;
	logic                    in_port;
	logic                    in_addr;

	// The length byte seen by the port window is the arriving byte at its own offset.
	always_comb begin
		vl_sel     = (offset_q == OFS_VER_LEN) ? data_byte : ver_len_q;
		port_start = OFS_HEAD_END + OFFSET_WIDTH'({vl_sel[3:0], 2'b00});
		port_diff  = offset_q - port_start;
		addr_diff  = offset_q - OFS_ADDR_FIRST;
		in_port    = (offset_q >= OFS_VER_LEN) && (offset_q >= port_start) &&
			(port_diff < OFS_PORT_LEN);
		in_addr    = (offset_q >= OFS_ADDR_FIRST) && (offset_q <= OFS_ADDR_LAST);
	end

	// Merge the current byte into the captured fields.
	always_comb begin
		view.pos     = offset_q;
		view.head    = head_q;
		view.ver_len = ver_len_q;
		view.proto   = proto_q;
		view.addr    = addr_q;
		view.ports   = ports_q;
		for (int i = 0; i < 8; i++) begin
			if (offset_q == OFFSET_WIDTH'(i)) begin
				view.head[63-8*i -: 8] = head_q[63-8*i -: 8] | data_byte;
			end
			if (in_addr && (addr_diff[2:0] == 3'(i))) begin
				view.addr[63-8*i -: 8] = addr_q[63-8*i -: 8] | data_byte;
			end
		end
		if (offset_q == OFS_VER_LEN) begin
			view.ver_len = data_byte;
		end
		if (offset_q == OFS_PROTO) begin
			view.proto = data_byte;
		end
		for (int j = 0; j < 4; j++) begin
			if (in_port && (port_diff[1:0] == 2'(j))) begin
				view.ports[31-8*j -: 8] = ports_q[31-8*j -: 8] | data_byte;
			end
		end
	end

	// State update: keep the merged view, or clear everything after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			head_q    <= '0;
			ver_len_q <= '0;
			proto_q   <= '0;
			addr_q    <= '0;
			ports_q   <= '0;
		end else if (advance) begin
			if (last_byte) begin
				offset_q  <= '0;
				head_q    <= '0;
				ver_len_q <= '0;
				proto_q   <= '0;
				addr_q    <= '0;
				ports_q   <= '0;
			end else begin
				if (offset_q != OFFSET_MAX) begin
					offset_q <= offset_q + OFFSET_WIDTH'(1);
				end
				head_q    <= view.head;
				ver_len_q <= view.ver_len;
				proto_q   <= view.proto;
				addr_q    <= view.addr;
				ports_q   <= view.ports;
			end
		end
	end

endmodule

// File: rtl/core/icmphfe_record.sv
`timescale 1ns / 1ps

module icmphfe_record (
	input  icmphfe_pkg::cap_view_t view,
	output icmphfe_pkg::rec_t      rec
);
	import icmphfe_pkg::*;

	logic [7:0]              ty;
	logic                    is_error;
	logic                    inner_ok;
	logic                    ports_ok;
	logic [OFFSET_WIDTH-1:0] ports_end;

	// Length rules for the embedded header and the transport ports.
	always_comb begin
		ty        = view.head[63:56];
		is_error  = ty inside {TYPE_DEST_UNREACH, TYPE_REDIRECT, TYPE_TIME_EXCEEDED,
			TYPE_PARAM_PROBLEM};
		ports_end = POS_PORTS_END + OFFSET_WIDTH'({view.ver_len[3:0], 2'b00});
		inner_ok  = is_error && (view.pos >= OFS_ADDR_LAST) &&
			(view.ver_len[7:4] == IP_VERSION_4);
		ports_ok  = inner_ok && (view.proto inside {PROTO_TCP, PROTO_UDP}) &&
			(view.pos >= ports_end);
	end

	// Build the record, zeroing fields whose length rule is not met.
	always_comb begin
		rec = '0;
		if (view.pos < POS_MIN_SHORT) begin
			rec.status = STATUS_TRUNCATED;
		end else begin
			rec.msg_type = ty;
			rec.msg_code = view.head[55:48];
			if (view.pos < POS_MIN_FULL) begin
				rec.status = STATUS_SHORT;
			end else begin
				rec.status   = STATUS_FULL;
				rec.echo_id  = view.head[31:16];
				rec.echo_seq = view.head[15:0];
				if (inner_ok) begin
					rec.inner_valid = 1'b1;
					rec.inner_proto = view.proto;
					rec.inner_src   = view.addr[63:32];
					rec.inner_dst   = view.addr[31:0];
				end
				if (ports_ok) begin
					rec.ports_valid = 1'b1;
					rec.src_port    = view.ports[31:16];
					rec.dst_port    = view.ports[15:0];
				end
			end
		end
	end

endmodule

// File: rtl/core/icmpv4_header_field_extractor.sv
`timescale 1ns / 1ps

// ICMPv4 header field extractor. Takes one message byte per item, type byte first, with
// last_byte set on the final byte, and sustains one item per clock cycle while input is
// not held off. Each byte passes through an input register and is merged into the
// captured header state. On the final byte one result record is written into the output
// register. The record therefore shows on the outputs after its last byte has passed the
// input register and the output register. Non-final bytes produce no result. Input is held
// off only while a stalled record waits in the output register and the byte in the input
// register is another final byte.
module icmpv4_header_field_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  msg_type,
	output logic [7:0]  msg_code,
	output logic [15:0] echo_id,
	output logic [15:0] echo_seq,
	output logic        inner_valid,
	output logic [7:0]  inner_proto,
	output logic [31:0] inner_src,
	output logic [31:0] inner_dst,
	output logic        ports_valid,
	output logic [15:0] src_port,
	output logic [15:0] dst_port
);
	import icmphfe_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_valid_q;
	rec_t       rec_q;
	logic       out_free;
	logic       advance;
	cap_view_t  view;
	rec_t       rec;

	// A byte moves on unless it would produce a record while the output is full.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	icmphfe_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.view      (view)
	);

	icmphfe_record u_record (
		.view (view),
		.rec  (rec)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			rec_q <= rec;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = rec_q.status;
	assign msg_type    = rec_q.msg_type;
	assign msg_code    = rec_q.msg_code;
	assign echo_id     = rec_q.echo_id;
	assign echo_seq    = rec_q.echo_seq;
	assign inner_valid = rec_q.inner_valid;
	assign inner_proto = rec_q.inner_proto;
	assign inner_src   = rec_q.inner_src;
	assign inner_dst   = rec_q.inner_dst;
	assign ports_valid = rec_q.ports_valid;
	assign src_port    = rec_q.src_port;
	assign dst_port    = rec_q.dst_port;

endmodule

// File: rtl/core/icmphfe_checker.sv
`timescale 1ns / 1ps

module icmphfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  data_byte,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [7:0]  msg_type,
	input logic [7:0]  msg_code,
	input logic [15:0] echo_id,
	input logic [15:0] echo_seq,
	input logic        inner_valid,
	input logic [7:0]  inner_proto,
	input logic [31:0] inner_src,
	input logic [31:0] inner_dst,
	input logic        ports_valid,
	input logic [15:0] src_port,
	input logic [15:0] dst_port
);
	import icmphfe_pkg::*;

	// A stalled record holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(src_port) &&
			$stable(inner_src) && $stable(echo_id))
		else $error("stalled record changed");

	// A truncated message reports no header fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_TRUNCATED) |->
			(msg_type == 8'd0) && (msg_code == 8'd0) && !inner_valid)
		else $error("truncated record carries fields");

	// Only full headers of an error type may carry an embedded header.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inner_valid |-> (status == STATUS_FULL) &&
			((msg_type == TYPE_DEST_UNREACH) || (msg_type == TYPE_REDIRECT) ||
			(msg_type == TYPE_TIME_EXCEEDED) || (msg_type == TYPE_PARAM_PROBLEM)))
		else $error("embedded header on a non-error record");

	// Ports are reported only for an embedded TCP or UDP header.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ports_valid |-> inner_valid &&
			((inner_proto == PROTO_TCP) || (inner_proto == PROTO_UDP)))
		else $error("ports reported without TCP or UDP");

	// Without ports the port fields are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ports_valid |-> (src_port == 16'd0) && (dst_port == 16'd0))
		else $error("port fields set without valid ports");

endmodule

bind icmpv4_header_field_extractor icmphfe_checker u_icmphfe_checker (.*);
